### sv/vdbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbf_pkg
// Shared types, constants and helpers of the value domain bitmap filter.
// ----------------------------------------------------------------------------
package vdbf_pkg;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int OUT_W   = 40;

    // Code 3 is unused and changes nothing.
    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_TEST = 2'd1,
        OP_NEXT = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOCATE,
        ST_FIRST,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } state_t;

    // Index of the lowest set bit of a word; zero for an empty word.
    function automatic logic [5:0] lowest_set(input logic [63:0] w);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if (w[i])
            begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

endpackage

### sv/vdbf_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbf_locate
// Maps a value to its bitmap word and bit offset by reciprocal multiplication:
// offset = value mod WORD_BITS, slot = (value / WORD_BITS) mod WORD_COUNT.
// Value, quotients and result are registered in turn; the result holds until a later one.
// ----------------------------------------------------------------------------
module vdbf_locate #(
    parameter int WORD_COUNT = 16,
    parameter int WORD_BITS  = 64
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [vdbf_pkg::VALUE_W-1:0]                      value,
    output logic                                              done,
    output logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1)-1:0] slot,
    output logic [$clog2(WORD_BITS)-1:0]                      ofs
);
    import vdbf_pkg::*;

    localparam int SLOT_W   = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int OFS_W    = $clog2(WORD_BITS);
    localparam int MAP_BITS = WORD_COUNT * WORD_BITS;
    localparam int WORD_SH  = VALUE_W + $clog2(WORD_BITS);
    localparam int MAP_SH   = VALUE_W + $clog2(MAP_BITS);
    localparam int PROD_W   = 2 * VALUE_W + 1;

    // With sh = 32 + ceil(log2 d), floor(2^sh / d) + 1 gives an exact
    // floor(v / d) for every 32-bit v.
    localparam logic [VALUE_W:0] WORD_RCP =
        (VALUE_W+1)'(((64'd1 << WORD_SH) / 64'(WORD_BITS)) + 64'd1);
    localparam logic [VALUE_W:0] MAP_RCP =
        (VALUE_W+1)'(((64'd1 << MAP_SH) / 64'(MAP_BITS)) + 64'd1);

    logic                val_vld_reg, val_vld_next;
    logic                quo_vld_reg, quo_vld_next;
    logic                done_reg, done_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [VALUE_W-1:0]  word_q_reg, word_q_next;
    logic [VALUE_W-1:0]  map_q_reg, map_q_next;
    logic [OFS_W-1:0]    ofs_reg, ofs_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    // The word quotient and the map quotient are formed side by side; the
    // slot is the word quotient less whole maps.
    always_comb
    begin
        logic [PROD_W-1:0]  word_prod;
        logic [PROD_W-1:0]  map_prod;
        logic [VALUE_W-1:0] word_base;
        logic [VALUE_W-1:0] map_base;
        word_prod = PROD_W'(val_reg) * PROD_W'(WORD_RCP);
        map_prod  = PROD_W'(val_reg) * PROD_W'(MAP_RCP);
        word_base = word_q_reg * VALUE_W'(WORD_BITS);
        map_base  = map_q_reg * VALUE_W'(WORD_COUNT);

        val_vld_next = start;
        quo_vld_next = val_vld_reg;
        done_next    = quo_vld_reg;
        val_next     = val_reg;
        word_q_next  = word_q_reg;
        map_q_next   = map_q_reg;
        ofs_next     = ofs_reg;
        slot_next    = slot_reg;
        if (start)
        begin
            val_next = value;
        end
        if (val_vld_reg)
        begin
            word_q_next = VALUE_W'(word_prod >> WORD_SH);
            map_q_next  = VALUE_W'(map_prod >> MAP_SH);
        end
        if (quo_vld_reg)
        begin
            ofs_next  = OFS_W'(val_reg - word_base);
            slot_next = SLOT_W'(word_q_reg - map_base);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_vld_reg <= 1'b0;
            quo_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            val_vld_reg <= val_vld_next;
            quo_vld_reg <= quo_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        word_q_reg <= word_q_next;
        map_q_reg  <= map_q_next;
        ofs_reg    <= ofs_next;
        slot_reg   <= slot_next;
    end

    assign done = done_reg;
    assign slot = slot_reg;
    assign ofs  = ofs_reg;

endmodule

### sv/vdbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdbf_ram
// Simple dual-port bitmap memory: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module vdbf_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/value_domain_bitmap_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_domain_bitmap_filter
// Value domain with bounds and a folded bitmap: add, membership test and
// search for the next set value.
//
//  Port group | Direction | Contents
//  s_*        | in        | tuser: op[1:0]; tdata: value[31:0]
//  m_*        | out       | tdata: qualifies[0], found[1], candidate[33:2]
//
// Add and test pass through the accepting cycle, the location of the bitmap
// word by reciprocal multiplication and the issue of its read, a step that
// uses the read data and a step that loads the output register. Next
// additionally reads one bitmap word per cycle, up to WORD_COUNT more, and,
// once a set bit turns up, checks the bound in a step of its own.
// An unused op code goes from the accepting cycle straight to the output load.
// After reset every bitmap word is cleared before s_tready rises.
// A finished result waits in the output register while a new transaction is
// accepted; the block stalls only when a second result is ready before the
// first has been taken.
// ----------------------------------------------------------------------------
module value_domain_bitmap_filter #(
    parameter int WORD_COUNT = 16,
    parameter int WORD_BITS  = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vdbf_pkg::VALUE_W-1:0]       s_tdata,  // value[31:0]
    input  logic [vdbf_pkg::OP_W-1:0]          s_tuser,  // op[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vdbf_pkg::OUT_W-1:0]         m_tdata   // qualifies, found, candidate[31:0]
);
    import vdbf_pkg::*;

    localparam int SLOT_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int OFS_W  = $clog2(WORD_BITS);
    localparam int K_W    = $clog2(WORD_COUNT + 1);
    localparam int DIST_W = $clog2((WORD_COUNT + 1) * WORD_BITS) + 1;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [VALUE_W-1:0]   val_reg, val_next;
    logic [VALUE_W-1:0]   lowest_reg, lowest_next;
    logic [VALUE_W-1:0]   highest_reg, highest_next;
    logic [DIST_W-1:0]    dist_reg, dist_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [SLOT_W-1:0]    clr_reg, clr_next;
    logic                 res_q_reg, res_q_next;
    logic                 res_f_reg, res_f_next;
    logic [VALUE_W-1:0]   res_c_reg, res_c_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    logic                 loc_start;
    logic [VALUE_W-1:0]   loc_value;
    logic                 loc_done;
    logic [SLOT_W-1:0]    loc_slot;
    logic [OFS_W-1:0]     loc_ofs;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    vdbf_locate #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_BITS  (WORD_BITS)
    ) u_locate (
        .clk   (clk),
        .rst_n (rst_n),
        .start (loc_start),
        .value (loc_value),
        .done  (loc_done),
        .slot  (loc_slot),
        .ofs   (loc_ofs)
    );

    vdbf_ram #(
        .DEPTH  (WORD_COUNT),
        .WIDTH  (WORD_BITS),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] i);
        logic [SLOT_W-1:0] n;
        if (i == SLOT_W'(WORD_COUNT - 1))
        begin
            n = '0;
        end
        else
        begin
            n = i + SLOT_W'(1);
        end
        return n;
    endfunction

    always_comb
    begin
        logic [WORD_BITS-1:0] masked;
        logic [OFS_W-1:0]     first_bit;
        logic [OFS_W-1:0]     scan_bit;
        logic [VALUE_W:0]     sum;
        op_t                  in_op;

        in_op = op_t'(s_tuser);
        for (int i = 0; i < WORD_BITS; i++)
        begin
            masked[i] = ram_rdata[i] && (i >= int'(loc_ofs));
        end
        first_bit = OFS_W'(lowest_set(64'(masked)));
        scan_bit  = OFS_W'(lowest_set(64'(ram_rdata)));
        sum       = {1'b0, val_reg} + (VALUE_W+1)'(dist_reg);

        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        lowest_next    = lowest_reg;
        highest_next   = highest_reg;
        dist_next      = dist_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        clr_next       = clr_reg;
        res_q_next     = res_q_reg;
        res_f_next     = res_f_reg;
        res_c_next     = res_c_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        s_tready  = 1'b0;
        loc_start = 1'b0;
        loc_value = s_tdata;
        ram_we    = 1'b0;
        ram_waddr = loc_slot;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << loc_ofs);
        ram_re    = 1'b0;
        ram_raddr = loc_slot;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = wrap_inc(clr_reg);
                if (clr_reg == SLOT_W'(WORD_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next    = in_op;
                    val_next   = s_tdata;
                    res_q_next = 1'b0;
                    res_f_next = 1'b0;
                    res_c_next = '0;
                    if (in_op == OP_NEXT && s_tdata < lowest_reg)
                    begin
                        val_next  = lowest_reg;
                        loc_value = lowest_reg;
                    end
                    case (in_op)
                        OP_ADD:
                        begin
                            if (s_tdata < lowest_reg)
                            begin
                                lowest_next = s_tdata;
                            end
                            if (s_tdata > highest_reg)
                            begin
                                highest_next = s_tdata;
                            end
                            loc_start  = 1'b1;
                            state_next = ST_LOCATE;
                        end
                        OP_TEST, OP_NEXT:
                        begin
                            loc_start  = 1'b1;
                            state_next = ST_LOCATE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LOCATE:
            begin
                if (loc_done)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_FIRST;
                end
            end

            ST_FIRST:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        ram_we     = 1'b1;
                        state_next = ST_DONE;
                    end
                    OP_TEST:
                    begin
                        res_q_next = (val_reg >= lowest_reg) && (val_reg <= highest_reg)
                                     && ram_rdata[loc_ofs];
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        if (masked != '0)
                        begin
                            dist_next  = DIST_W'(first_bit) - DIST_W'(loc_ofs);
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            // Bits from the start offset to the end of this word.
                            dist_next  = DIST_W'(WORD_BITS) - DIST_W'(loc_ofs);
                            idx_next   = wrap_inc(loc_slot);
                            k_next     = K_W'(1);
                            ram_re     = 1'b1;
                            ram_raddr  = wrap_inc(loc_slot);
                            state_next = ST_SCAN;
                        end
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (ram_rdata != '0)
                begin
                    dist_next  = dist_reg + DIST_W'(scan_bit);
                    state_next = ST_FINISH;
                end
                else if (k_reg == K_W'(WORD_COUNT))
                begin
                    res_c_next = '1;
                    state_next = ST_DONE;
                end
                else
                begin
                    dist_next  = dist_reg + DIST_W'(WORD_BITS);
                    idx_next   = wrap_inc(idx_reg);
                    k_next     = k_reg + K_W'(1);
                    ram_re     = 1'b1;
                    ram_raddr  = wrap_inc(idx_reg);
                end
            end

            ST_FINISH:
            begin
                // The sum is one bit wider, so a pass beyond 2^32-1 fails too.
                if (sum <= {1'b0, highest_reg})
                begin
                    res_f_next = 1'b1;
                    res_c_next = sum[VALUE_W-1:0];
                end
                else
                begin
                    res_c_next = '1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'd0, res_c_reg, res_f_reg, res_q_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            lowest_reg    <= '1;
            highest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            lowest_reg    <= lowest_next;
            highest_reg   <= highest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        dist_reg     <= dist_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        res_q_reg    <= res_q_next;
        res_f_reg    <= res_f_next;
        res_c_reg    <= res_c_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### dv/value_domain_bitmap_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_domain_bitmap_filter_test
// Self-checking bench for the value domain bitmap filter. Add, test, next
// and unused-code transactions go in through the slave stream with random
// gaps. A scoreboard keeps its own copy of the bounds and the folded bitmap
// and predicts every result. Results leave through the master stream under
// random back pressure and are compared field by field in order.
// ----------------------------------------------------------------------------
module value_domain_bitmap_filter_test;

    import vdbf_pkg::*;

    localparam int          MAP_BITS     = 16 * 64;
    localparam int          RANDOM_ITEMS = 1030;
    localparam int          QUIET_ITEMS  = 150;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam logic [31:0] DOMAIN_BASE  = 32'h0010_0005;

    typedef struct packed {
        logic        qualifies;
        logic        found;
        logic [31:0] candidate;
    } outcome_t;

    class domain_scoreboard;
        logic [31:0] lowest;
        logic [31:0] highest;
        logic [63:0] words [16];
        outcome_t    outcome_q [$];
        int          errors;

        function new();
            lowest  = '1;
            highest = '0;
            foreach (words[k])
            begin
                words[k] = '0;
            end
            errors = 0;
        endfunction

        function bit bit_set(logic [31:0] value);
            int p;
            p = int'(value % MAP_BITS);
            return words[p / 64][p % 64];
        endfunction

        // Updates the domain for an accepted transaction and queues its result.
        function void note_request(logic [1:0] op, logic [31:0] value);
            outcome_t    exp;
            logic [31:0] start;
            logic [32:0] sum;
            int          gap;
            bit          hit;
            exp = '0;
            case (op)
                OP_ADD:
                begin
                    if (value < lowest)
                    begin
                        lowest = value;
                    end
                    if (value > highest)
                    begin
                        highest = value;
                    end
                    words[int'(value % MAP_BITS) / 64][int'(value % MAP_BITS) % 64] = 1'b1;
                end
                OP_TEST:
                begin
                    exp.qualifies = (value >= lowest) && (value <= highest) && bit_set(value);
                end
                OP_NEXT:
                begin
                    exp.candidate = '1;
                    start = (value < lowest) ? lowest : value;
                    if (start <= highest)
                    begin
                        // A circular bit scan gives the same distance as the word-wise search.
                        hit = 1'b0;
                        gap = 0;
                        for (int d = 0; d < MAP_BITS; d++)
                        begin
                            if (!hit && bit_set(start + 32'(d)))
                            begin
                                hit = 1'b1;
                                gap = d;
                            end
                        end
                        sum = {1'b0, start} + 33'(gap);
                        if (hit && sum <= {1'b0, highest})
                        begin
                            exp.found     = 1'b1;
                            exp.candidate = sum[31:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
            outcome_q.push_back(exp);
        endfunction

        function void check_result(logic [OUT_W-1:0] tdata);
            outcome_t exp;
            if (outcome_q.size() == 0)
            begin
                $error("result with no transaction pending: tdata %h", tdata);
                errors++;
                return;
            end
            exp = outcome_q.pop_front();
            if (tdata[0] !== exp.qualifies)
            begin
                $error("qualifies: expected %0d, actual %0d", exp.qualifies, tdata[0]);
                errors++;
            end
            if (tdata[1] !== exp.found)
            begin
                $error("found: expected %0d, actual %0d", exp.found, tdata[1]);
                errors++;
            end
            if (tdata[33:2] !== exp.candidate)
            begin
                $error("candidate: expected %h, actual %h", exp.candidate, tdata[33:2]);
                errors++;
            end
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;
    logic [1:0]         s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b1;
    logic [OUT_W-1:0]   m_tdata;

    domain_scoreboard   sb;
    logic [31:0]        added_q [$];
    bit                 quiet = 1'b0;
    int                 cycle_count = 0;

    always #4 clk = ~clk;

    value_domain_bitmap_filter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Drives one transaction and returns in the step of its acceptance.
    task automatic send_item(logic [1:0] op, logic [31:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_request(op, value);
        if (op == OP_ADD)
        begin
            added_q.push_back(value);
        end
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
    endtask

    // Most values fall in a window around the domain; some lie within one of an added value.
    function automatic logic [31:0] pick_value(bit for_add);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (for_add ? (r < 2) : (r < 10))
        begin
            return $urandom;
        end
        if (r < 35 && added_q.size() > 0)
        begin
            return added_q[$urandom_range(0, added_q.size() - 1)] + $urandom_range(0, 2) - 1;
        end
        return DOMAIN_BASE - 32'd1500 + $urandom_range(0, 7700);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 99) < 8)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("value_domain_bitmap_filter_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned r;
        logic [1:0]  op;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty domain: nothing qualifies and no search succeeds.
        send_item(OP_TEST, 32'h0000_0000);
        send_item(OP_TEST, 32'hFFFF_FFFF);
        send_item(OP_NEXT, 32'h0000_0000);
        send_item(OP_NEXT, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, 32'h0000_0000);

        // Two values that fold onto the same bit, four maps apart.
        send_item(OP_ADD, DOMAIN_BASE);
        send_item(OP_ADD, DOMAIN_BASE + 32'd4096);
        send_item(OP_NEXT, 32'h0000_0000);
        // Full wrap back to the start word's low bits.
        send_item(OP_NEXT, DOMAIN_BASE + 32'd10);
        send_item(OP_NEXT, DOMAIN_BASE + 32'd1);
        send_item(OP_TEST, DOMAIN_BASE + 32'd1024);
        send_item(OP_TEST, DOMAIN_BASE - 32'd1024);
        send_item(OP_TEST, DOMAIN_BASE + 32'd1);

        // Top bit of word 0, then a search that starts at bit 0 of word 1.
        send_item(OP_ADD, DOMAIN_BASE + 32'd58);
        send_item(OP_NEXT, DOMAIN_BASE + 32'd1);
        send_item(OP_NEXT, DOMAIN_BASE + 32'd59);
        send_item(OP_NEXT, DOMAIN_BASE + 32'd4096);
        send_item(OP_NEXT, DOMAIN_BASE + 32'd4097);
        send_item(OP_NEXT, 32'hFFFF_FFFF);
        send_item(OP_TEST, DOMAIN_BASE + 32'd4096);
        send_item(OP_TEST, 32'hFFFF_FFFF);
        send_item(OP_UNUSED, DOMAIN_BASE);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
            if (!quiet && $urandom_range(0, 99) < 20)
            begin
                pause_sender();
            end
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                op = OP_ADD;
            end
            else if (r < 45)
            begin
                op = OP_TEST;
            end
            else if (r < 94)
            begin
                op = OP_NEXT;
            end
            else
            begin
                op = OP_UNUSED;
            end
            send_item(op, pick_value(op == OP_ADD));
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("value_domain_bitmap_filter_test: PASS");
        end
        else
        begin
            $display("value_domain_bitmap_filter_test: FAIL");
        end
        $finish;
    end

endmodule

### files.f
sv/vdbf_pkg.sv
sv/vdbf_locate.sv
sv/vdbf_ram.sv
sv/value_domain_bitmap_filter.sv
dv/value_domain_bitmap_filter_test.sv
